// ===== design/wma_pkg.sv =====
package wma_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_RST = 8'd8;
  localparam logic [CFG_W-1:0] WEIGHT_RST = 8'd1;

  localparam logic KIND_FILL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SHIFT,
    ST_NEWEST,
    ST_ADD,
    ST_DIVS,
    ST_DIVW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ===== design/weighted_moving_average.sv =====
// Weighted moving average of signed Q8.8 samples.
// Input channel: in_valid/in_ready with in_kind and in_sample. kind 0 filters
// a sample and gives one out_mean; kind 1 writes the value into every history
// entry and gives no result.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 sets the
// window length, 1 the weight of the newest sample. Write only while idle.
// Output channel: out_valid/out_ready with out_mean, held in an output
// register; a stalled receiver holds the result and the block waits at its
// final step until the register frees, while in_ready stays low.
// Throughput: one request at a time; the next request is taken in the same
// cycle that out_valid rises. The time a sample takes grows with n (the
// effective window) and is set by the history walk through the RAM (one
// entry per cycle) and the radix-2 divider (one quotient bit per cycle,
// 24 bits); a zero divisor skips the divider. A fill request writes one
// RAM entry per cycle, MAX_SAMPLES + 1 entries in all, and the next
// request is taken in the cycle after the last write.
// Reset: history reads as zero through per-entry valid bits, fill count
// zero, window 8, weight 1; no clearing pass is needed.
module weighted_moving_average
  import wma_pkg::*;
#(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_mean,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  localparam int DEPTH = MAX_SAMPLES + 1;
  localparam int CNT_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DIV_W = CMP_W + 1;
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES + (1 << CFG_W));
  localparam int MAG_W = SUM_W - 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]           window_r, window_nxt;
  logic [CFG_W-1:0]           weight_r, weight_nxt;
  logic [CNT_W-1:0]           fill_cnt_r, fill_cnt_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic [CNT_W-1:0]           k_r, k_nxt;
  logic [DEPTH-1:0]           hist_vld_r, hist_vld_nxt;
  logic                       rd_vld_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_mean_r, out_mean_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SUM_W-1:0]    prod_r, prod_nxt;
  logic [DIV_W-1:0]           dsor_r, dsor_nxt;
  logic                       neg_r, neg_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;

  logic                       mem_we;
  logic [CNT_W-1:0]           mem_waddr;
  logic [SAMPLE_W-1:0]        mem_wdata;
  logic                       mem_re;
  logic [CNT_W-1:0]           mem_raddr;
  logic [SAMPLE_W-1:0]        mem_rdata;
  logic signed [SAMPLE_W-1:0] hist_rd;

  logic [CNT_W-1:0]           cnt_new;
  logic signed [SUM_W-1:0]    sum_abs;
  logic [MAG_W-1:0]           quo;
  logic [MAG_W-1:0]           quo_s;
  div_ctl_t                   div_req;
  div_ctl_t                   div_rsp;

  wma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  wma_div #(
    .N_W(MAG_W),
    .D_W(DIV_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (div_req),
    .ctl_out (div_rsp),
    .dividend(sum_abs[MAG_W-1:0]),
    .divisor (dsor_r),
    .quotient(quo)
  );

  assign hist_rd = rd_vld_r ? signed'(mem_rdata) : '0;
  assign sum_abs = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign quo_s   = neg_r ? -quo : quo;

  always_comb begin
    if (CMP_W'(window_r) > CMP_W'(fill_cnt_r)) begin
      if (fill_cnt_r < CNT_W'(MAX_SAMPLES)) begin
        cnt_new = fill_cnt_r + 1'b1;
      end else begin
        cnt_new = fill_cnt_r;
      end
    end else begin
      cnt_new = CNT_W'(window_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    weight_nxt    = weight_r;
    fill_cnt_nxt  = fill_cnt_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    hist_vld_nxt  = hist_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mean_nxt  = out_mean_r;
    sample_nxt    = sample_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    dsor_nxt      = dsor_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = k_r;
    mem_wdata     = sample_r;
    mem_re        = 1'b0;
    mem_raddr     = k_r + 1'b1;
    div_req       = '0;
    in_ready      = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW: window_nxt = cfg_wdata;
        CFG_WEIGHT: weight_nxt = cfg_wdata;
        default:    ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sample_nxt = in_sample;
          k_nxt      = '0;
          if (in_kind == KIND_FILL) begin
            state_nxt = ST_FILL;
          end else begin
            fill_cnt_nxt = cnt_new;
            n_nxt        = cnt_new;
            sum_nxt      = '0;
            state_nxt    = ST_SHIFT;
          end
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = k_r;
        k_nxt     = k_r + 1'b1;
        if (k_r == CNT_W'(MAX_SAMPLES)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        mem_re = k_r < n_r;
        if (k_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = k_r - 1'b1;
          mem_wdata = hist_rd;
          sum_nxt   = sum_r + SUM_W'(hist_rd);
        end
        if (k_r == n_r) begin
          state_nxt = ST_NEWEST;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_NEWEST: begin
        mem_we    = 1'b1;
        mem_waddr = n_r;
        prod_nxt  = SUM_W'(signed'({1'b0, weight_r})) * SUM_W'(sample_r);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        sum_nxt   = sum_r + prod_r;
        dsor_nxt  = DIV_W'(n_r) + DIV_W'(weight_r);
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        if (dsor_r == '0) begin
          res_nxt   = sample_r;
          state_nxt = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          neg_nxt       = sum_r[SUM_W-1];
          state_nxt     = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          res_nxt   = signed'(quo_s[SAMPLE_W-1:0]);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (mem_we) begin
      hist_vld_nxt[mem_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RST;
      weight_r    <= WEIGHT_RST;
      fill_cnt_r  <= '0;
      hist_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      weight_r    <= weight_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      hist_vld_r  <= hist_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    out_mean_r <= out_mean_nxt;
    sample_r   <= sample_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    dsor_r     <= dsor_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    if (mem_re) begin
      rd_vld_r <= hist_vld_r[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== design/wma_ram.sv =====
module wma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/wma_div.sv =====
module wma_div
  import wma_pkg::*;
#(
  parameter int N_W = 24,
  parameter int D_W = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  div_ctl_t       ctl_in,
  output div_ctl_t       ctl_out,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic [N_W-1:0] quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [N_W-1:0] q_r, q_nxt;
  logic [D_W-1:0] rem_r, rem_nxt;
  logic [D_W-1:0] dsor_r, dsor_nxt;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  always_comb begin
    trial    = {rem_r, q_r[N_W-1]};
    ge       = trial >= {1'b0, dsor_r};
    diff     = trial - {1'b0, dsor_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    if (ctl_in.start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsor_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      q_nxt   = {q_r[N_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(N_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
  end

  always_comb begin
    ctl_out       = '0;
    ctl_out.start = ctl_in.start;
    ctl_out.done  = done_r;
  end

  assign quotient = q_r;

endmodule

// ===== design/wma_checker.sv =====
module wma_checker
  import wma_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_mean,
  input logic                       cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a request in flight");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind weighted_moving_average wma_checker u_wma_checker (.*);

// ===== dv/wma_mean_checker.sv =====
`timescale 1ns / 1ps

module wma_mean_checker
  import wma_pkg::*;
#(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_mean,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  output int                         fail_count,
  output int                         pending_means
);

  logic signed [SAMPLE_W-1:0] hist [0:MAX_SAMPLES];
  logic [5:0]                 fill_cnt;
  logic [CFG_W-1:0]           win_len;
  logic [CFG_W-1:0]           new_wt;
  logic signed [SAMPLE_W-1:0] mean_queue [$];

  task automatic absorb_request(input logic kind, input logic signed [SAMPLE_W-1:0] smp);
    int n;
    int acc;
    int dvs;
    logic signed [SAMPLE_W-1:0] avg;
    if (kind == KIND_FILL) begin
      foreach (hist[i]) hist[i] = smp;
      return;
    end
    n = win_len;
    if (n > fill_cnt) begin
      if (fill_cnt < MAX_SAMPLES) fill_cnt++;
      n = fill_cnt;
    end else begin
      fill_cnt = n;
    end
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      hist[i] = hist[i + 1];
      acc += hist[i];
    end
    hist[n] = smp;
    acc += int'(new_wt) * smp;
    dvs = n + int'(new_wt);
    avg = (dvs != 0) ? SAMPLE_W'(acc / dvs) : smp;
    mean_queue.push_back(avg);
  endtask

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      foreach (hist[i]) hist[i] = '0;
      fill_cnt = '0;
      win_len = WINDOW_RST;
      new_wt = WEIGHT_RST;
      mean_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW: win_len = cfg_wdata;
          CFG_WEIGHT: new_wt = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (mean_queue.size() == 0) begin
          $error("mean: no result expected, actual %0d", out_mean);
          fail_count++;
        end else begin
          want = mean_queue.pop_front();
          if (out_mean !== want) begin
            $error("mean mismatch: expected %0d, actual %0d", want, out_mean);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) absorb_request(in_kind, in_sample);
    end
    pending_means <= mean_queue.size();
  end

endmodule

// ===== dv/tb_weighted_moving_average.sv =====
`timescale 1ns / 1ps

module tb_weighted_moving_average;
  import wma_pkg::*;

  localparam int   MAX_SAMPLES = 32;
  localparam int   SETTLE      = 100;
  localparam int   CYCLE_LIMIT = 1_000_000;
  localparam logic KIND_SAMPLE = 1'b0;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_kind = KIND_SAMPLE;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_mean;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_WINDOW;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  int fail_count;
  int pending_means;
  int cycle_count = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 48;
  int n_requests = 0;
  int n_fills = 0;
  int n_writes = 0;

  weighted_moving_average #(.MAX_SAMPLES(MAX_SAMPLES)) dut (.*);

  wma_mean_checker #(.MAX_SAMPLES(MAX_SAMPLES)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_request(input logic kind, input logic signed [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    n_requests++;
    if (kind == KIND_FILL) n_fills++;
  endtask

  // hold off until every mean is back and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_means != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] wt);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= win;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_WEIGHT;
    cfg_wdata <= wt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes += 2;
  endtask

  initial begin
    logic                       req_kind;
    logic signed [SAMPLE_W-1:0] req_sample;
    logic [CFG_W-1:0]           win;
    logic [CFG_W-1:0]           wt;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: window 8, weight 1
    send_request(KIND_SAMPLE, 16'sh7FFF);
    send_request(KIND_SAMPLE, 16'sh8000);
    send_request(KIND_SAMPLE, 16'sh0001);
    send_request(KIND_FILL,   16'sh8000);
    send_request(KIND_SAMPLE, 16'sh8000);
    send_request(KIND_FILL,   16'sh7FFF);
    send_request(KIND_SAMPLE, 16'sh7FFF);

    // zero window, zero weight: divisor is zero, mean passes the sample
    drain();
    write_config(8'd0, 8'd0);
    send_request(KIND_SAMPLE, 16'sh1234);
    send_request(KIND_SAMPLE, 16'sh8000);
    send_request(KIND_SAMPLE, 16'sh7FFF);

    drain();
    write_config(8'd0, 8'd1);
    send_request(KIND_SAMPLE, -16'sd5);

    // negative sums truncate toward zero
    drain();
    write_config(8'd1, 8'd2);
    send_request(KIND_SAMPLE, -16'sd1);
    send_request(KIND_SAMPLE, -16'sd2);
    send_request(KIND_SAMPLE, 16'sd3);
    send_request(KIND_SAMPLE, -16'sd7);

    // window above history size, largest weight
    drain();
    write_config(8'd255, 8'd255);
    send_request(KIND_SAMPLE, 16'sh7FFF);
    send_request(KIND_SAMPLE, 16'sh8000);
    send_request(KIND_SAMPLE, 16'sh7FFF);
    send_request(KIND_SAMPLE, 16'sh8000);
    send_request(KIND_SAMPLE, 16'sh0000);
    send_request(KIND_FILL,   16'shFFFF);
    send_request(KIND_SAMPLE, 16'sh0000);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 10 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        case (seg)
          0: begin win = 8'd255; wt = 8'd255; end
          1: begin win = 8'd0;   wt = 8'd1;   end
          2: begin win = CFG_W'($urandom_range(40)); wt = CFG_W'($urandom_range(1, 255)); end
          default: begin win = CFG_W'($urandom_range(255)); wt = CFG_W'($urandom_range(1, 255)); end
        endcase
        write_config(win, wt);
        for (int k = 0; k < 60; k++) begin
          case ($urandom_range(7))
            0: req_sample = 16'sh7FFF;
            1: req_sample = 16'sh8000;
            2: req_sample = SAMPLE_W'($urandom_range(64)) - 16'sd32;
            default: req_sample = SAMPLE_W'($urandom);
          endcase
          req_kind = ($urandom_range(99) < 8) ? KIND_FILL : KIND_SAMPLE;
          send_request(req_kind, req_sample);
        end
      end
    end

    drain();
    $display("Run covered %0d requests (%0d history fills) and %0d register writes,",
             n_requests, n_fills, n_writes);
    $display("windows 0 to 255, weights 0 to 255, under three sender/receiver stall mixes.");
    if (fail_count == 0 && pending_means == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
